/* sv/smlc_pkg.sv */
// Shared types and constants for the sliding median level classifier.
package smlc_pkg;

  localparam int unsigned SMP_W   = 16;
  localparam int unsigned LVL_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SMP_W-1:0] RST_THR_LOW  = 16'd1000;
  localparam logic [SMP_W-1:0] RST_THR_MID  = 16'd2600;
  localparam logic [SMP_W-1:0] RST_THR_HIGH = 16'd8000;

  localparam logic [LVL_W-1:0] LVL_1 = 3'd1;
  localparam logic [LVL_W-1:0] LVL_2 = 3'd2;
  localparam logic [LVL_W-1:0] LVL_3 = 3'd3;
  localparam logic [LVL_W-1:0] LVL_4 = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_LOW  = 2'd0,
    CFG_THR_MID  = 2'd1,
    CFG_THR_HIGH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SMP_W-1:0] low;
    logic [SMP_W-1:0] mid;
    logic [SMP_W-1:0] high;
  } thr_t;

endpackage

/* sv/smlc_cell.sv */
// One window cell: holds a sample, passes it on, and works out its own sorted rank.
module smlc_cell
  import smlc_pkg::*;
#(
  parameter int unsigned N   = 5,
  parameter int unsigned IDX = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    shift_i,
  input  logic [SMP_W-1:0]        din_i,
  input  logic [N-1:0][SMP_W-1:0] win_i,
  output logic [SMP_W-1:0]        val_o,
  output logic                    sel_o
);

  localparam int unsigned RANK_W = $clog2(N);

  logic [SMP_W-1:0]  val_q;
  logic [RANK_W-1:0] rank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (shift_i) begin
      val_q <= din_i;
    end
  end

  // rank = entries strictly below, plus equal entries in lower cells (ties broken by position)
  always_comb begin
    rank = '0;
    for (int j = 0; j < int'(N); j++) begin
      if (j != int'(IDX)) begin
        if ((win_i[j] < val_q) || ((j < int'(IDX)) && (win_i[j] == val_q))) begin
          rank = rank + 1'b1;
        end
      end
    end
  end

  assign val_o = val_q;
  assign sel_o = (rank == RANK_W'(N / 2));

endmodule

/* sv/smlc_class.sv */
// Level classifier stage: registers the median and its threshold class.
module smlc_class
  import smlc_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SMP_W-1:0] med_i,
  input  thr_t             thr_i,
  output logic [SMP_W-1:0] median_o,
  output logic [LVL_W-1:0] level_o
);

  logic [SMP_W-1:0] median_q;
  logic [LVL_W-1:0] level_q, level_d;

  // first threshold the median falls below wins
  always_comb begin
    if (med_i < thr_i.low) begin
      level_d = LVL_1;
    end else if (med_i < thr_i.mid) begin
      level_d = LVL_2;
    end else if (med_i < thr_i.high) begin
      level_d = LVL_3;
    end else begin
      level_d = LVL_4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      median_q <= med_i;
      level_q  <= level_d;
    end
  end

  assign median_o = median_q;
  assign level_o  = level_q;

endmodule

/* sv/sliding_median_level_classifier.sv */
// Registers: the sample in the cell row, the median in med_q, then median and class.
// Throughput: one sample per cycle unless stalled; each cell ranks itself against the
// whole window combinationally; that compare-and-count in the cell row sets the rate.
// An output stall on a waiting result freezes all three stages and stalls the input.
// Reset (async, active low): window cleared to zeros, thresholds to 1000/2600/8000,
// pipeline empty.
module sliding_median_level_classifier
  import smlc_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SMP_W-1:0]     sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SMP_W-1:0]     median_value_o,
  output logic [LVL_W-1:0]     level_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SMP_W-1:0]     cfg_data_i
);

  thr_t thr_q;

  logic en;
  logic accept;
  logic a_vld_q, b_vld_q, o_vld_q;

  logic [WINDOW_LEN-1:0][SMP_W-1:0] win;
  logic [WINDOW_LEN-1:0]            sel;
  logic [SMP_W-1:0]                 med;
  logic [SMP_W-1:0]                 med_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.low  <= RST_THR_LOW;
      thr_q.mid  <= RST_THR_MID;
      thr_q.high <= RST_THR_HIGH;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_THR_LOW:  thr_q.low  <= cfg_data_i;
        CFG_THR_MID:  thr_q.mid  <= cfg_data_i;
        CFG_THR_HIGH: thr_q.high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !o_vld_q || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      o_vld_q <= b_vld_q;
    end
  end

  // cell row as a shift line: oldest sample drops off the far end
  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
    logic [SMP_W-1:0] din;
    if (k == 0) begin : g_head
      assign din = sample_i;
    end else begin : g_body
      assign din = win[k-1];
    end
    smlc_cell #(
      .N   (WINDOW_LEN),
      .IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .din_i   (din),
      .win_i   (win),
      .val_o   (win[k]),
      .sel_o   (sel[k])
    );
  end

  // ranks are a permutation, so exactly one cell is selected
  always_comb begin
    med = '0;
    for (int k = 0; k < int'(WINDOW_LEN); k++) begin
      if (sel[k]) begin
        med = med | win[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      med_q <= med;
    end
  end

  smlc_class u_class (
    .clk_i    (clk_i),
    .en_i     (en),
    .med_i    (med_q),
    .thr_i    (thr_q),
    .median_o (median_value_o),
    .level_o  (level_o)
  );

  assign out_valid_o = o_vld_q;

endmodule

/* sv/smlc_chk.sv */
// Port-level checker for the sliding median level classifier, bound to the top level.
module smlc_chk
  import smlc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [SMP_W-1:0]     median_value_o,
  input logic [LVL_W-1:0]     level_o
);

  logic       in_xfer, out_xfer;
  logic [2:0] pend_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // items taken in but not yet handed out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b00, in_xfer} - {2'b00, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(median_value_o) && $stable(level_o))
    else $error("stalled result changed");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_o == LVL_1 || level_o == LVL_2 || level_o == LVL_3 ||
                     level_o == LVL_4))
    else $error("level out of range");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result without a pending sample");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("too many samples in flight");

  a_take_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind sliding_median_level_classifier smlc_chk u_smlc_chk (.*);

/* tb/sv/sliding_median_level_checker.sv */
// Checker: tracks the sample window and thresholds, predicts each result and compares.
`timescale 1ns / 100ps
module sliding_median_level_checker
  import smlc_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [SMP_W-1:0]     sample_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [SMP_W-1:0]     median_value_i,
  input  logic [LVL_W-1:0]     level_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SMP_W-1:0]     cfg_data_i,
  output int                   err_count_o,
  output int                   pending_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SMP_W-1:0] median;
    logic [LVL_W-1:0] level;
  } median_level_t;

  logic [SMP_W-1:0] window_q [WINDOW_LEN];
  int unsigned      wr_pos_q;
  thr_t             thr_q;
  median_level_t    expected_q [$];
  int               err_count;

  function automatic logic [SMP_W-1:0] window_median();
    logic [SMP_W-1:0] sorted [WINDOW_LEN];
    logic [SMP_W-1:0] key;
    int               b;
    for (int a = 0; a < WINDOW_LEN; a++) sorted[a] = window_q[a];
    for (int a = 1; a < WINDOW_LEN; a++) begin
      key = sorted[a];
      b = a - 1;
      while (b >= 0 && sorted[b] > key) begin
        sorted[b + 1] = sorted[b];
        b--;
      end
      sorted[b + 1] = key;
    end
    // upper middle entry for an even length
    return sorted[WINDOW_LEN / 2];
  endfunction

  // first threshold the median falls below wins, whatever their order
  function automatic logic [LVL_W-1:0] classify_level(input logic [SMP_W-1:0] median);
    if (median < thr_q.low) return LVL_1;
    if (median < thr_q.mid) return LVL_2;
    if (median < thr_q.high) return LVL_3;
    return LVL_4;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : p_model
    median_level_t got;
    median_level_t want;
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_LEN; k++) window_q[k] = '0;
      wr_pos_q    = 0;
      thr_q.low   = RST_THR_LOW;
      thr_q.mid   = RST_THR_MID;
      thr_q.high  = RST_THR_HIGH;
      expected_q.delete();
      err_count   = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_THR_LOW:  thr_q.low  = cfg_data_i;
          CFG_THR_MID:  thr_q.mid  = cfg_data_i;
          CFG_THR_HIGH: thr_q.high = cfg_data_i;
          default: ;
        endcase
      end
      // a result never leaves in the same cycle its sample is taken, so compare before pushing
      if (out_valid_i && !out_stall_i) begin
        got.median = median_value_i;
        got.level  = level_i;
        if (expected_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: result median %0d level %0d with no sample outstanding",
                     $time, got.median, got.level);
          end
        end else begin
          want = expected_q.pop_front();
          if (got.median !== want.median || got.level !== want.level) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("%0t: expected median %0d level %0d, got median %0d level %0d",
                       $time, want.median, want.level, got.median, got.level);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        window_q[wr_pos_q] = sample_i;
        wr_pos_q = (wr_pos_q == WINDOW_LEN - 1) ? 0 : wr_pos_q + 1;
        want.median = window_median();
        want.level  = classify_level(want.median);
        expected_q.push_back(want);
      end
      err_count_o <= err_count;
      pending_o   <= expected_q.size();
    end
  end

endmodule

/* tb/sv/sliding_median_level_classifier_tb.sv */
// Testbench top: drives samples and threshold writes, idles both sides and gives the verdict.
`timescale 1ns / 100ps
module sliding_median_level_classifier_tb;
  import smlc_pkg::*;

  localparam int unsigned WINDOW_LEN   = 5;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 285;
  localparam int unsigned PRESSURE_PH  = 4;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  // index with no register behind it: writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [SMP_W-1:0]     sample_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [SMP_W-1:0]     median_value_o;
  logic [LVL_W-1:0]     level_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SMP_W-1:0]     cfg_data_i  = '0;

  int               err_count;
  int               pending;
  bit               no_gaps  = 1'b0;
  bit               hold_req = 1'b0;
  thr_t             cur_thr;
  logic [SMP_W-1:0] centre   = '0;
  logic [SMP_W-1:0] directed_q [$];

  sliding_median_level_classifier #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .median_value_o(median_value_o),
    .level_o       (level_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  sliding_median_level_checker #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .median_value_i(median_value_o),
    .level_i       (level_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(4_000_000);
    $display("FAIL");
    $finish;
  end

  // result side: random stall before each transfer, one long hold-off on request
  initial begin : p_result_sink
    int unsigned n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 7);
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while (!out_valid_o);
    end
  end

  task automatic send_sample(input logic [SMP_W-1:0] value);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SMP_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
  endtask

  task automatic set_thresholds(input thr_t thr);
    write_reg(CFG_THR_LOW, thr.low);
    write_reg(CFG_IDX_UNUSED, 16'($urandom));
    write_reg(CFG_THR_MID, thr.mid);
    write_reg(CFG_THR_HIGH, thr.high);
    cfg_valid_i <= 1'b0;
    cur_thr = thr;
  endtask

  // stop offering, then wait for every outstanding result and let the pipe settle
  task automatic wait_drained();
    int unsigned cycles;
    in_valid_i <= 1'b0;
    cycles = 0;
    do begin
      @(posedge clk_i);
      cycles++;
    end while (pending != 0 && cycles < DRAIN_LIMIT);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // chiefly a slowly wandering level so medians settle, plus threshold edges, noise and 0/65535
  function automatic logic [SMP_W-1:0] pick_sample();
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0:       centre = cur_thr.low;
          1:       centre = cur_thr.mid;
          2:       centre = cur_thr.high;
          default: centre = 16'($urandom);
        endcase
      end
      v = int'(centre) + int'($urandom_range(0, 64)) - 32;
    end else if (sel < 6) begin
      case ($urandom_range(0, 2))
        0:       v = int'(cur_thr.low);
        1:       v = int'(cur_thr.mid);
        default: v = int'(cur_thr.high);
      endcase
      v = v + int'($urandom_range(0, 4)) - 2;
    end else if (sel < 8) begin
      v = int'($urandom_range(0, 65535));
    end else if (sel == 8) begin
      v = 0;
    end else begin
      v = 65535;
    end
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return v[SMP_W-1:0];
  endfunction

  initial begin : p_stimulus
    thr_t thr;
    logic [SMP_W-1:0] t;
    cur_thr.low  = RST_THR_LOW;
    cur_thr.mid  = RST_THR_MID;
    cur_thr.high = RST_THR_HIGH;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full and alternating bit patterns against the start-up zeros, then runs across each
    // reset threshold so the median sits on either side of it, then a run of zeros
    directed_q = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555,
                   16'd999, 16'd999, 16'd999, 16'd1000, 16'd1000, 16'd1000,
                   16'd2600, 16'd2600, 16'd2600, 16'd7999, 16'd7999, 16'd7999,
                   16'd8000, 16'd8000, 16'd8000, 16'h0000, 16'h0000, 16'h0000};
    foreach (directed_q[k]) send_sample(directed_q[k]);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: thr = '{16'h0000, 16'h0000, 16'h0000};
        1: thr = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: thr = '{16'($urandom), 16'($urandom), 16'($urandom)};
        PRESSURE_PH: thr = '{RST_THR_LOW, RST_THR_MID, RST_THR_HIGH};
        default: begin
          thr.low  = 16'($urandom_range(0, 20000));
          thr.mid  = thr.low + 16'($urandom_range(0, 20000));
          thr.high = thr.mid + 16'($urandom_range(0, 25000));
        end
      endcase
      // not ascending: low at or above mid
      if (p == 2 && thr.low < thr.mid) begin
        t = thr.low;
        thr.low = thr.mid;
        thr.mid = t;
      end
      set_thresholds(thr);
      centre = thr.mid;
      if (p == PRESSURE_PH) begin
        no_gaps  = 1'b1;
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 64 == 0 && !(p == PRESSURE_PH && i < 128)) begin
          no_gaps = ($urandom_range(0, 3) == 0);
        end
        send_sample(pick_sample());
      end
      wait_drained();
    end

    if (err_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sliding_median_level_classifier.f */
sv/smlc_pkg.sv
sv/smlc_cell.sv
sv/smlc_class.sv
sv/sliding_median_level_classifier.sv
sv/smlc_chk.sv
tb/sv/sliding_median_level_checker.sv
tb/sv/sliding_median_level_classifier_tb.sv
